FILE: sv/lobm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lobm_pkg;

  // Request kinds carried in s_axis_tuser
  typedef enum logic [1:0] {
    OP_LIMIT      = 2'd0,
    OP_MARKET     = 2'd1,
    OP_CANCEL_ID  = 2'd2,
    OP_CANCEL_POS = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_BAD_PRICE = 3'd1,
    STS_BAD_QTY   = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_BOOK_FULL = 3'd4
  } status_e;

  // What the scan token looks for
  typedef enum logic [1:0] {
    SRCH_MATCH = 2'd0,  // best price on a side, then oldest
    SRCH_ID    = 2'd1,  // first live slot with a given id
    SRCH_RANK  = 2'd2   // oldest at a level, newer than a threshold key
  } srch_e;

  typedef enum logic [1:0] {
    UPD_NONE  = 2'd0,
    UPD_WRITE = 2'd1,
    UPD_QTY   = 2'd2,   // new quantity, zero frees the slot
    UPD_CLEAR = 2'd3
  } upd_e;

  localparam logic REC_FILL  = 1'b0;
  localparam logic REC_FINAL = 1'b1;

  typedef struct packed {
    srch_e       mode;
    logic        side;
    logic [7:0]  price;
    logic [31:0] id;
    logic        thr_valid;
    logic [31:0] thr_id;
  } query_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  price;
    logic [31:0] id;
    logic [31:0] qty;
    logic [15:0] owner;
  } token_t;

  typedef struct packed {
    upd_e        op;
    logic        side;
    logic [7:0]  price;
    logic [31:0] id;
    logic [31:0] qty;
    logic [15:0] owner;
  } upd_t;

endpackage

`default_nettype wire

FILE: sv/limit_order_book_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// A scan pass runs the token through the cell row (S_SCAN), then S_RESULT acts on it.
// Limit/market: passes = fills+1, or fills when the last fill empties it or hits MAX_ORDERS.
// Cancel by id 1 pass; cancel by position up to position+1 passes; rejects 0 passes.
// One request in flight; S_IDLE, entered as the final record loads, takes the next.
// Reset (async, active low): book empty, num_ticks = NUM_PRICES, next order id 1.
module limit_order_book_matcher #(
  parameter int unsigned NUM_PRICES = 256,
  parameter int unsigned MAX_ORDERS = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // tdata: side[0], price[8:1], quantity[40:9], owner[56:41], order_id[88:57],
  //        position[93:89], zero pad[95:94]
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,
  input  wire logic [1:0]   s_axis_tuser,   // operation
  // tdata: status[2:0], aggr_id[34:3], maker_id[66:35], fill_price[74:67],
  //        fill_qty[106:75], aggr_side[107], maker_owner[123:108],
  //        taker_owner[139:124], filled_total[171:140], zero pad[175:172]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [175:0]      m_axis_tdata,
  output logic              m_axis_tuser,   // record_kind
  output logic              m_axis_tlast,   // is_last
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [8:0]   cfg_data_i      // num_ticks
);
  import lobm_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_ORDERS);
  localparam int unsigned FCNT_W = $clog2(MAX_ORDERS + 1);
  localparam int unsigned NT_W   = $clog2(NUM_PRICES + 1);
  localparam int unsigned CMP_W  = (NT_W > 9) ? NT_W : 9;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_RESULT = 5'b01000,
    S_FINAL  = 5'b10000
  } state_e;

  state_e      state_q;
  op_e         op_q;
  logic        side_q;
  logic [7:0]  price_q;
  logic [31:0] qty_q;
  logic [15:0] owner_q;
  logic [31:0] oid_q;
  logic [4:0]  pos_q;
  logic [31:0] rem_q;
  logic [31:0] filled_q;
  logic [31:0] tid_q;
  logic [FCNT_W-1:0] fills_q;
  logic [31:0] next_id_q;
  logic [NT_W-1:0] num_ticks_q;
  query_t      qry_q;
  logic [IDX_W-1:0] thr_idx_q;
  logic [IDX_W-1:0] cnt_q;
  logic [4:0]  pass_q;
  status_e     fin_status_q;
  logic [31:0] fin_taker_q;
  logic [31:0] fin_total_q;
  logic        fin_rest_q;

  // output register
  logic        o_valid_q;
  logic        o_kind_q;
  status_e     o_status_q;
  logic [31:0] o_taker_q;
  logic [31:0] o_maker_q;
  logic [7:0]  o_price_q;
  logic [31:0] o_qty_q;
  logic        o_tside_q;
  logic [15:0] o_mown_q;
  logic [15:0] o_town_q;
  logic [31:0] o_total_q;

  // cell row
  token_t           tok   [MAX_ORDERS+1];
  logic [IDX_W-1:0] tok_idx [MAX_ORDERS+1];
  logic [MAX_ORDERS-1:0] slot_valid;
  upd_t             upd;
  logic [IDX_W-1:0] upd_idx;

  assign tok[0]     = '0;
  assign tok_idx[0] = '0;

  for (genvar i = 0; i < MAX_ORDERS; i++) begin : g_cell
    lobm_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .qry_i     (qry_q),
      .thr_idx_i (thr_idx_q),
      .upd_i     (upd),
      .upd_idx_i (upd_idx),
      .tok_i     (tok[i]),
      .tok_idx_i (tok_idx[i]),
      .tok_o     (tok[i+1]),
      .tok_idx_o (tok_idx[i+1]),
      .valid_o   (slot_valid[i])
    );
  end

  token_t           win;
  logic [IDX_W-1:0] win_idx;
  logic             bad_price;
  logic             crosses;
  logic [31:0]      amt;
  logic [31:0]      rem_nx;
  logic [FCNT_W-1:0] fills_nx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             out_free;
  logic             o_load;
  logic             cfg_wr;
  logic             book_full;
  logic             rest_write;
  logic             is_trade;
  logic [CMP_W-1:0] cfg_ext;
  logic [NT_W-1:0]  cfg_sat;

  assign win     = tok[MAX_ORDERS];
  assign win_idx = tok_idx[MAX_ORDERS];

  // num_ticks only changes between requests; a pending write wins over a new request
  assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign cfg_wr        = cfg_valid_i && cfg_ready_o;
  assign out_free      = !o_valid_q || m_axis_tready;
  assign is_trade      = (op_q == OP_LIMIT) || (op_q == OP_MARKET);

  assign bad_price = CMP_W'(price_q) >= CMP_W'(num_ticks_q);
  // bid taker crosses asks at or below its limit, ask taker bids at or above
  assign crosses = (op_q == OP_MARKET) ||
                   (side_q ? (win.price >= price_q) : (win.price <= price_q));
  assign amt      = (rem_q < win.qty) ? rem_q : win.qty;
  assign rem_nx   = rem_q - amt;
  assign fills_nx = fills_q + FCNT_W'(1);

  // output register loads a fill or the final record
  assign o_load = out_free &&
                  ((state_q == S_FINAL) ||
                   ((state_q == S_RESULT) && is_trade && win.hit && crosses));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign book_full  = fin_rest_q && (rem_q != 32'd0) && !free_found;
  assign rest_write = (state_q == S_FINAL) && out_free && fin_rest_q &&
                      (rem_q != 32'd0) && free_found;

  // saturate num_ticks to 2 .. NUM_PRICES
  assign cfg_ext = CMP_W'(cfg_data_i);
  always_comb begin
    if (cfg_ext < CMP_W'(2)) begin
      cfg_sat = NT_W'(2);
    end else if (cfg_ext > CMP_W'(NUM_PRICES)) begin
      cfg_sat = NT_W'(NUM_PRICES);
    end else begin
      cfg_sat = NT_W'(cfg_ext);
    end
  end

  // slot update broadcast
  always_comb begin
    upd       = '0;
    upd.op    = UPD_NONE;
    upd_idx   = '0;
    if (cfg_wr) begin
      upd.op = UPD_CLEAR;
    end else if (state_q == S_RESULT && win.hit) begin
      if (is_trade && crosses && out_free) begin
        upd.op  = UPD_QTY;
        upd.qty = win.qty - amt;
        upd_idx = win_idx;
      end else if (op_q == OP_CANCEL_ID ||
                   (op_q == OP_CANCEL_POS && pass_q == pos_q)) begin
        upd.op  = UPD_QTY;
        upd.qty = 32'd0;
        upd_idx = win_idx;
      end
    end else if (rest_write) begin
      upd.op    = UPD_WRITE;
      upd.side  = side_q;
      upd.price = price_q;
      upd.id    = tid_q;
      upd.qty   = rem_q;
      upd.owner = owner_q;
      upd_idx   = free_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_LIMIT;
      side_q       <= 1'b0;
      price_q      <= '0;
      qty_q        <= '0;
      owner_q      <= '0;
      oid_q        <= '0;
      pos_q        <= '0;
      rem_q        <= '0;
      filled_q     <= '0;
      tid_q        <= '0;
      fills_q      <= '0;
      next_id_q    <= 32'd1;
      num_ticks_q  <= NT_W'(NUM_PRICES);
      qry_q        <= '0;
      thr_idx_q    <= '0;
      cnt_q        <= '0;
      pass_q       <= '0;
      fin_status_q <= STS_OK;
      fin_taker_q  <= '0;
      fin_total_q  <= '0;
      fin_rest_q   <= 1'b0;
      o_valid_q    <= 1'b0;
      o_kind_q     <= REC_FILL;
      o_status_q   <= STS_OK;
      o_taker_q    <= '0;
      o_maker_q    <= '0;
      o_price_q    <= '0;
      o_qty_q      <= '0;
      o_tside_q    <= 1'b0;
      o_mown_q     <= '0;
      o_town_q     <= '0;
      o_total_q    <= '0;
    end else begin
      if (o_load) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid_q <= 1'b0;
      end
      if (cfg_wr) num_ticks_q <= cfg_sat;

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op_q     <= op_e'(s_axis_tuser);
            side_q   <= s_axis_tdata[0];
            price_q  <= s_axis_tdata[8:1];
            qty_q    <= s_axis_tdata[40:9];
            owner_q  <= s_axis_tdata[56:41];
            oid_q    <= s_axis_tdata[88:57];
            pos_q    <= s_axis_tdata[93:89];
            rem_q    <= s_axis_tdata[40:9];
            filled_q <= '0;
            fills_q  <= '0;
            pass_q   <= '0;
            state_q  <= S_CHECK;
          end
        end

        S_CHECK: begin
          fin_rest_q  <= 1'b0;
          fin_taker_q <= '0;
          fin_total_q <= '0;
          cnt_q       <= '0;
          qry_q.thr_valid <= 1'b0;
          qry_q.price     <= price_q;
          qry_q.id        <= oid_q;
          case (op_q)
            OP_LIMIT, OP_MARKET: begin
              if (op_q == OP_LIMIT && bad_price) begin
                fin_status_q <= STS_BAD_PRICE;
                state_q      <= S_FINAL;
              end else if (qty_q == 32'd0) begin
                fin_status_q <= STS_BAD_QTY;
                state_q      <= S_FINAL;
              end else begin
                tid_q       <= next_id_q;
                next_id_q   <= (next_id_q == 32'hFFFF_FFFF) ? 32'd1 : next_id_q + 32'd1;
                qry_q.mode  <= SRCH_MATCH;
                qry_q.side  <= ~side_q;
                state_q     <= S_SCAN;
              end
            end
            OP_CANCEL_ID: begin
              if (oid_q == 32'd0) begin
                fin_status_q <= STS_NOT_FOUND;
                state_q      <= S_FINAL;
              end else begin
                qry_q.mode <= SRCH_ID;
                state_q    <= S_SCAN;
              end
            end
            default: begin
              if (bad_price) begin
                fin_status_q <= STS_BAD_PRICE;
                state_q      <= S_FINAL;
              end else begin
                qry_q.mode <= SRCH_RANK;
                qry_q.side <= side_q;
                state_q    <= S_SCAN;
              end
            end
          endcase
        end

        S_SCAN: begin
          cnt_q <= cnt_q + IDX_W'(1);
          if (cnt_q == IDX_W'(MAX_ORDERS - 1)) state_q <= S_RESULT;
        end

        S_RESULT: begin
          cnt_q <= '0;
          case (op_q)
            OP_LIMIT, OP_MARKET: begin
              if (win.hit && crosses) begin
                if (out_free) begin
                  o_kind_q   <= REC_FILL;
                  o_status_q <= STS_OK;
                  o_taker_q  <= tid_q;
                  o_maker_q  <= win.id;
                  o_price_q  <= win.price;
                  o_qty_q    <= amt;
                  o_tside_q  <= side_q;
                  o_mown_q   <= win.owner;
                  o_town_q   <= owner_q;
                  o_total_q  <= '0;
                  rem_q      <= rem_nx;
                  filled_q   <= filled_q + amt;
                  fills_q    <= fills_nx;
                  if (rem_nx != 32'd0 && fills_nx < FCNT_W'(MAX_ORDERS)) begin
                    state_q <= S_SCAN;
                  end else begin
                    fin_status_q <= STS_OK;
                    fin_taker_q  <= tid_q;
                    fin_total_q  <= filled_q + amt;
                    fin_rest_q   <= (op_q == OP_LIMIT);
                    state_q      <= S_FINAL;
                  end
                end
              end else begin
                fin_status_q <= STS_OK;
                fin_taker_q  <= tid_q;
                fin_total_q  <= filled_q;
                fin_rest_q   <= (op_q == OP_LIMIT);
                state_q      <= S_FINAL;
              end
            end
            OP_CANCEL_ID: begin
              fin_status_q <= win.hit ? STS_OK : STS_NOT_FOUND;
              fin_taker_q  <= win.hit ? oid_q : 32'd0;
              state_q      <= S_FINAL;
            end
            default: begin
              if (!win.hit) begin
                fin_status_q <= STS_NOT_FOUND;
                state_q      <= S_FINAL;
              end else if (pass_q == pos_q) begin
                fin_status_q <= STS_OK;
                fin_taker_q  <= win.id;
                state_q      <= S_FINAL;
              end else begin
                // next rank: oldest order newer than this one
                qry_q.thr_valid <= 1'b1;
                qry_q.thr_id    <= win.id;
                thr_idx_q       <= win_idx;
                pass_q          <= pass_q + 5'd1;
                state_q         <= S_SCAN;
              end
            end
          endcase
        end

        S_FINAL: begin
          if (out_free) begin
            o_kind_q   <= REC_FINAL;
            o_status_q <= book_full ? STS_BOOK_FULL : fin_status_q;
            o_taker_q  <= fin_taker_q;
            o_maker_q  <= '0;
            o_price_q  <= '0;
            o_qty_q    <= '0;
            o_tside_q  <= 1'b0;
            o_mown_q   <= '0;
            o_town_q   <= '0;
            o_total_q  <= fin_total_q;
            state_q    <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_kind_q;
  assign m_axis_tdata  = {4'd0, o_total_q, o_town_q, o_mown_q, o_tside_q, o_qty_q,
                          o_price_q, o_maker_q, o_taker_q, o_status_q};

  // outside idle, remainder and filled total add back to the request quantity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (rem_q + filled_q == qty_q))
    else $error("remainder and filled total disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fills_q <= FCNT_W'(MAX_ORDERS))
    else $error("fill count overran");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_kind_q == REC_FILL) |-> (o_qty_q != 32'd0))
    else $error("fill record with zero quantity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> (state_q == S_SCAN || state_q == S_RESULT))
    else $error("scan left early");

endmodule

`default_nettype wire

FILE: sv/lobm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One order slot plus one stage of the search token pipeline.
module lobm_cell #(
  parameter int unsigned IDX_W    = 5,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lobm_pkg::query_t     qry_i,
  input  wire logic [IDX_W-1:0]     thr_idx_i,
  input  wire lobm_pkg::upd_t       upd_i,
  input  wire logic [IDX_W-1:0]     upd_idx_i,
  input  wire lobm_pkg::token_t     tok_i,
  input  wire logic [IDX_W-1:0]     tok_idx_i,
  output lobm_pkg::token_t          tok_o,
  output logic [IDX_W-1:0]          tok_idx_o,
  output logic                      valid_o
);
  import lobm_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic        valid_q;
  logic        side_q;
  logic [7:0]  price_q;
  logic [31:0] id_q;
  logic [31:0] qty_q;
  logic [15:0] owner_q;
  token_t      tok_q;
  logic [IDX_W-1:0] tok_idx_q;

  logic sel;
  logic cand;
  logic better;

  assign sel = (upd_idx_i == MY_IDX);

  always_comb begin
    cand   = 1'b0;
    better = 1'b0;
    case (qry_i.mode)
      SRCH_MATCH: begin
        cand = valid_q && (side_q == qry_i.side);
        // ask makers: lowest price wins; bid makers: highest
        if (qry_i.side) begin
          better = (price_q < tok_i.price) ||
                   ((price_q == tok_i.price) && (id_q < tok_i.id));
        end else begin
          better = (price_q > tok_i.price) ||
                   ((price_q == tok_i.price) && (id_q < tok_i.id));
        end
      end
      SRCH_ID: begin
        cand   = valid_q && (id_q == qry_i.id);
        better = 1'b0;
      end
      SRCH_RANK: begin
        cand = valid_q && (side_q == qry_i.side) && (price_q == qry_i.price) &&
               (!qry_i.thr_valid || (id_q > qry_i.thr_id) ||
                ((id_q == qry_i.thr_id) && (MY_IDX > thr_idx_i)));
        better = (id_q < tok_i.id);
      end
      default: begin
        cand   = 1'b0;
        better = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      case (upd_i.op)
        UPD_CLEAR: valid_q <= 1'b0;
        UPD_WRITE: if (sel) valid_q <= 1'b1;
        UPD_QTY:   if (sel) valid_q <= |upd_i.qty;
        default:   valid_q <= valid_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.op == UPD_WRITE && sel) begin
      side_q  <= upd_i.side;
      price_q <= upd_i.price;
      id_q    <= upd_i.id;
      qty_q   <= upd_i.qty;
      owner_q <= upd_i.owner;
    end else if (upd_i.op == UPD_QTY && sel) begin
      qty_q <= upd_i.qty;
    end
    if (cand && (!tok_i.hit || better)) begin
      tok_q     <= '{hit: 1'b1, price: price_q, id: id_q, qty: qty_q, owner: owner_q};
      tok_idx_q <= MY_IDX;
    end else begin
      tok_q     <= tok_i;
      tok_idx_q <= tok_idx_i;
    end
  end

  assign tok_o     = tok_q;
  assign tok_idx_o = tok_idx_q;
  assign valid_o   = valid_q;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lobm_pkg::*;

  localparam int unsigned PRICES = 256;
  localparam int unsigned SLOTS  = 32;
  localparam int unsigned RAND_PER_PHASE = 64;

  // one record on the master side
  typedef struct {
    logic        kind;
    logic [2:0]  st;
    logic [31:0] taker;
    logic [31:0] maker;
    logic [7:0]  px;
    logic [31:0] fqty;
    logic        tside;
    logic [15:0] mown;
    logic [15:0] town;
    logic [31:0] total;
  } rec_t;

  // directed row: a request, or a num_ticks write when is_cfg is set
  typedef struct {
    bit          is_cfg;
    logic [8:0]  cfg;
    op_e         op;
    logic        side;
    logic [7:0]  price;
    logic [31:0] qty;
    logic [15:0] owner;
    logic [31:0] oid;
    logic [4:0]  pos;
    bit          has_exp;
    status_e     exp_st;
  } row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [175:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [8:0]   cfg_data_i;

  limit_order_book_matcher #(
    .NUM_PRICES(PRICES),
    .MAX_ORDERS(SLOTS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // ---------------------------------------------------------------
  // Book mirror: slot store, level counts, best prices, id counter
  // ---------------------------------------------------------------
  bit          slot_live [SLOTS];
  logic [31:0] slot_oid  [SLOTS];
  logic [31:0] slot_left [SLOTS];
  logic [15:0] slot_own  [SLOTS];
  logic        slot_sd   [SLOTS];
  logic [7:0]  slot_px   [SLOTS];
  int          lvl_cnt   [2][PRICES];
  int          best_bid;
  int          best_ask;
  int          side_cnt  [2];
  logic [31:0] next_id;
  int          ticks;

  rec_t expected_recs[$];   // records still owed by the block, oldest first
  int   errors = 0;
  bit   calm = 1'b0;        // last part of the run: no idling on either side
  int   stall_left = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h (t=%0t)", what, got, exp, $time);
  endtask

  function automatic void clear_book();
    for (int i = 0; i < SLOTS; i++) slot_live[i] = 0;
    for (int i = 0; i < PRICES; i++) begin
      lvl_cnt[0][i] = 0;
      lvl_cnt[1][i] = 0;
    end
    side_cnt[0] = 0;
    side_cnt[1] = 0;
    best_bid = -1;
    best_ask = ticks;
  endfunction

  function automatic void set_ticks(input logic [8:0] v);
    int t;
    t = v;
    if (t < 2) t = 2;
    if (t > PRICES) t = PRICES;
    ticks = t;
    clear_book();
  endfunction

  // age: lower id first, lower slot on a tie
  function automatic bit is_older(input int a, input int b);
    return slot_oid[a] < slot_oid[b] || (slot_oid[a] == slot_oid[b] && a < b);
  endfunction

  function automatic int kth_oldest(input logic sd, input int px, input int k);
    int rank;
    for (int a = 0; a < SLOTS; a++) begin
      if (!slot_live[a] || slot_sd[a] != sd || slot_px[a] != px) continue;
      rank = 0;
      for (int b = 0; b < SLOTS; b++)
        if (slot_live[b] && slot_sd[b] == sd && slot_px[b] == px && is_older(b, a)) rank++;
      if (rank == k) return a;
    end
    return -1;
  endfunction

  function automatic void refresh_best(input logic sd);
    int p;
    if (side_cnt[sd] == 0) begin
      if (sd == 0) best_bid = -1;
      else best_ask = ticks;
      return;
    end
    if (sd == 0) begin
      p = best_bid;
      if (p >= ticks) p = ticks - 1;
      while (p >= 0 && lvl_cnt[0][p] == 0) p--;
      best_bid = p;
    end else begin
      p = best_ask;
      if (p < 0) p = 0;
      while (p < ticks && lvl_cnt[1][p] == 0) p++;
      best_ask = p;
    end
  endfunction

  function automatic void drop_slot(input int s);
    logic sd;
    int   p;
    int   best;
    sd = slot_sd[s];
    p = slot_px[s];
    best = (sd == 0) ? best_bid : best_ask;
    slot_live[s] = 0;
    if (lvl_cnt[sd][p] > 0) lvl_cnt[sd][p]--;
    if (side_cnt[sd] > 0) side_cnt[sd]--;
    if (lvl_cnt[sd][p] == 0 && p == best) refresh_best(sd);
  endfunction

  function automatic void owe_final(input status_e st, input logic [31:0] id,
                                    input logic [31:0] total);
    rec_t r;
    r = '{kind: REC_FINAL, st: st, taker: id, maker: '0, px: '0, fqty: '0, tside: 1'b0,
          mown: '0, town: '0, total: total};
    expected_recs.insert(expected_recs.size(), r);
  endfunction

  // taker walks the opposite side; one fill per resting order touched, at most SLOTS
  function automatic logic [31:0] cross_book(input logic ts, input logic [31:0] qty_in,
                                             input int lim, input logic [31:0] tid,
                                             input logic [15:0] town);
    logic        mk;
    logic [31:0] qty;
    logic [31:0] filled;
    logic [31:0] q;
    int          p;
    int          s;
    int          nfill;
    bit          crosses;
    rec_t        r;
    mk = ~ts;
    qty = qty_in;
    filled = 0;
    nfill = 0;
    while (qty > 0 && nfill < SLOTS) begin
      crosses = (ts == 0) ? (best_ask < ticks && best_ask <= lim)
                          : (best_bid >= 0 && best_bid >= lim);
      if (!crosses) break;
      p = (ts == 0) ? best_ask : best_bid;
      while (qty > 0 && lvl_cnt[mk][p] > 0 && nfill < SLOTS) begin
        s = kth_oldest(mk, p, 0);
        if (s < 0) begin
          lvl_cnt[mk][p] = 0;
          break;
        end
        q = (qty < slot_left[s]) ? qty : slot_left[s];
        r = '{kind: REC_FILL, st: STS_OK, taker: tid, maker: slot_oid[s], px: p[7:0],
              fqty: q, tside: ts, mown: slot_own[s], town: town, total: '0};
        expected_recs.insert(expected_recs.size(), r);
        nfill++;
        slot_left[s] -= q;
        qty -= q;
        filled += q;
        if (slot_left[s] == 0) begin
          slot_live[s] = 0;
          lvl_cnt[mk][p]--;
          if (side_cnt[mk] > 0) side_cnt[mk]--;
        end
      end
      if (lvl_cnt[mk][p] == 0) refresh_best(mk);
    end
    return filled;
  endfunction

  // updates the mirror for one accepted request and queues what the block owes
  function automatic void book_request(input op_e op, input logic sd, input logic [7:0] price,
                                       input logic [31:0] qty, input logic [15:0] owner,
                                       input logic [31:0] oid, input logic [4:0] pos);
    logic [31:0] id;
    logic [31:0] filled;
    int          lim;
    int          f;
    status_e     st;
    case (op)
      OP_LIMIT, OP_MARKET: begin
        if (op == OP_LIMIT && price >= ticks) begin
          owe_final(STS_BAD_PRICE, '0, '0);
          return;
        end
        if (qty == 0) begin
          owe_final(STS_BAD_QTY, '0, '0);
          return;
        end
        id = next_id;
        next_id = next_id + 1;
        if (next_id == 0) next_id = 1;
        if (op == OP_LIMIT) lim = price;
        else lim = (sd == 0) ? ticks - 1 : 0;
        filled = cross_book(sd, qty, lim, id, owner);
        st = STS_OK;
        if (op == OP_LIMIT && qty != filled) begin
          f = -1;
          for (int s = 0; s < SLOTS; s++)
            if (!slot_live[s] && f < 0) f = s;
          if (f < 0) begin
            st = STS_BOOK_FULL;
          end else begin
            slot_live[f] = 1;
            slot_oid[f]  = id;
            slot_left[f] = qty - filled;
            slot_own[f]  = owner;
            slot_sd[f]   = sd;
            slot_px[f]   = price;
            lvl_cnt[sd][price]++;
            side_cnt[sd]++;
            if (sd == 0 && int'(price) > best_bid) best_bid = price;
            if (sd == 1 && int'(price) < best_ask) best_ask = price;
          end
        end
        owe_final(st, id, filled);
      end
      OP_CANCEL_ID: begin
        f = -1;
        if (oid != 0)
          for (int s = 0; s < SLOTS; s++)
            if (slot_live[s] && slot_oid[s] == oid && (f < 0 || is_older(s, f))) f = s;
        if (f < 0) begin
          owe_final(STS_NOT_FOUND, '0, '0);
        end else begin
          drop_slot(f);
          owe_final(STS_OK, oid, '0);
        end
      end
      default: begin
        if (price >= ticks) begin
          owe_final(STS_BAD_PRICE, '0, '0);
          return;
        end
        f = kth_oldest(sd, price, pos);
        if (f < 0) begin
          owe_final(STS_NOT_FOUND, '0, '0);
        end else begin
          id = slot_oid[f];
          drop_slot(f);
          owe_final(STS_OK, id, '0);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------
  // Clock, result side
  // ---------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stall bursts unless calm
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= (stall_left == 0);
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker, field by field against the oldest owed record
  always @(posedge clk_i) begin
    rec_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_recs.size() == 0) begin
        report("unexpected record", m_axis_tdata[34:3], '0);
      end else begin
        e = expected_recs[0];
        expected_recs.delete(0);
        if (m_axis_tuser != e.kind)                report("record_kind", m_axis_tuser, e.kind);
        if (m_axis_tlast != e.kind)                report("is_last", m_axis_tlast, e.kind);
        if (m_axis_tdata[2:0] != e.st)             report("status", m_axis_tdata[2:0], e.st);
        if (m_axis_tdata[34:3] != e.taker)         report("aggr_id", m_axis_tdata[34:3], e.taker);
        if (m_axis_tdata[66:35] != e.maker)        report("maker_id", m_axis_tdata[66:35], e.maker);
        if (m_axis_tdata[74:67] != e.px)           report("fill_price", m_axis_tdata[74:67], e.px);
        if (m_axis_tdata[106:75] != e.fqty)        report("fill_qty", m_axis_tdata[106:75], e.fqty);
        if (m_axis_tdata[107] != e.tside)          report("aggr_side", m_axis_tdata[107], e.tside);
        if (m_axis_tdata[123:108] != e.mown)       report("maker_owner", m_axis_tdata[123:108], e.mown);
        if (m_axis_tdata[139:124] != e.town)       report("taker_owner", m_axis_tdata[139:124], e.town);
        if (m_axis_tdata[171:140] != e.total)      report("filled_total", m_axis_tdata[171:140], e.total);
        if (m_axis_tdata[175:172] != 4'd0)         report("pad", m_axis_tdata[175:172], '0);
      end
    end
  end

  // ---------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------
  // sender gap: valid drops for a random burst, never in the calm part
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic send_request(input op_e op, input logic sd, input logic [7:0] price,
                              input logic [31:0] qty, input logic [15:0] owner,
                              input logic [31:0] oid, input logic [4:0] pos);
    maybe_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, pos, oid, owner, qty, price, sd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    book_request(op, sd, price, qty, owner, oid, pos);
  endtask

  // book must be quiet before num_ticks changes
  task automatic write_ticks(input logic [8:0] v);
    s_axis_tvalid <= 1'b0;
    while (expected_recs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    set_ticks(v);
  endtask

  task automatic random_request();
    op_e         op;
    logic        sd;
    logic [7:0]  price;
    logic [31:0] qty;
    logic [31:0] oid;
    logic [4:0]  pos;
    logic [31:0] live_ids[$];
    int          r;
    r  = $urandom_range(0, 99);
    op = (r < 50) ? OP_LIMIT : (r < 65) ? OP_MARKET : (r < 82) ? OP_CANCEL_ID : OP_CANCEL_POS;
    sd = 1'($urandom_range(0, 1));
    // bids mostly low, asks mostly high, so orders rest and the book fills up
    if (ticks < PRICES && $urandom_range(0, 19) == 0)
      price = 8'($urandom_range(ticks, PRICES - 1));
    else if ($urandom_range(0, 4) == 0)
      price = 8'($urandom_range(0, ticks - 1));
    else if (sd == 0)
      price = 8'($urandom_range(0, ticks / 2));
    else
      price = 8'($urandom_range((ticks - 1) / 2, ticks - 1));
    case ($urandom_range(0, 19))
      0:       qty = '0;
      1:       qty = 32'hFFFF_FFFF;
      2:       qty = $urandom;
      default: qty = $urandom_range(1, 20);
    endcase
    for (int s = 0; s < SLOTS; s++)
      if (slot_live[s]) live_ids.insert(live_ids.size(), slot_oid[s]);
    if (live_ids.size() != 0 && $urandom_range(0, 3) != 0)
      oid = live_ids[$urandom_range(0, live_ids.size() - 1)];
    else
      case ($urandom_range(0, 2))
        0:       oid = '0;
        1:       oid = $urandom;
        default: oid = next_id - 1;
      endcase
    pos = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 3));
    send_request(op, sd, price, qty, 16'($urandom), oid, pos);
  endtask

  // directed part: extremes, every operation, bad price, bad qty and not found codes
  row_t plan[] = '{
    '{0, 0, OP_LIMIT,      0, 8'd0,   32'd0,          16'h0000, 0,            0,     1, STS_BAD_QTY},
    '{0, 0, OP_MARKET,     1, 8'd0,   32'd0,          16'h0000, 0,            0,     1, STS_BAD_QTY},
    '{0, 0, OP_LIMIT,      0, 8'd10,  32'd5,          16'hFFFF, 0,            0,     0, STS_OK},
    '{0, 0, OP_LIMIT,      1, 8'd255, 32'hFFFF_FFFF,  16'h0000, 0,            0,     0, STS_OK},
    '{0, 0, OP_MARKET,     0, 8'd0,   32'd3,          16'h1234, 0,            0,     0, STS_OK},
    '{0, 0, OP_MARKET,     1, 8'd255, 32'd10,         16'hABCD, 0,            0,     0, STS_OK},
    '{0, 0, OP_CANCEL_ID,  0, 8'd0,   32'd0,          16'h0000, 32'd0,        0,     1, STS_NOT_FOUND},
    '{0, 0, OP_CANCEL_ID,  1, 8'd0,   32'd0,          16'h0000, 32'hFFFF_FFFF, 0,    1, STS_NOT_FOUND},
    '{0, 0, OP_CANCEL_ID,  0, 8'd0,   32'd0,          16'h0000, 32'd2,        0,     0, STS_OK},
    '{0, 0, OP_CANCEL_POS, 0, 8'd0,   32'd0,          16'h0000, 0,            5'd31, 1, STS_NOT_FOUND},
    '{0, 0, OP_LIMIT,      1, 8'd20,  32'd7,          16'h0001, 0,            0,     0, STS_OK},
    '{0, 0, OP_LIMIT,      1, 8'd20,  32'd8,          16'h0002, 0,            0,     0, STS_OK},
    '{0, 0, OP_LIMIT,      1, 8'd21,  32'd9,          16'h0003, 0,            0,     0, STS_OK},
    '{0, 0, OP_CANCEL_POS, 1, 8'd20,  32'd0,          16'h0000, 0,            5'd1,  0, STS_OK},
    '{0, 0, OP_LIMIT,      0, 8'd30,  32'd100,        16'h7777, 0,            0,     0, STS_OK},
    '{0, 0, OP_CANCEL_POS, 0, 8'd30,  32'd0,          16'h0000, 0,            5'd0,  0, STS_OK},
    // num_ticks 0 saturates to 2
    '{1, 9'd0, OP_LIMIT,   0, 8'd0,   32'd0,          16'h0000, 0,            0,     0, STS_OK},
    '{0, 0, OP_LIMIT,      0, 8'd2,   32'd1,          16'h0000, 0,            0,     1, STS_BAD_PRICE},
    '{0, 0, OP_CANCEL_POS, 1, 8'd255, 32'd0,          16'h0000, 0,            0,     1, STS_BAD_PRICE},
    '{0, 0, OP_LIMIT,      0, 8'd1,   32'd4,          16'h5555, 0,            0,     0, STS_OK},
    '{0, 0, OP_LIMIT,      1, 8'd0,   32'd1,          16'hAAAA, 0,            0,     0, STS_OK},
    '{0, 0, OP_MARKET,     1, 8'd0,   32'hFFFF_FFFF,  16'h0F0F, 0,            0,     0, STS_OK}
  };

  logic [8:0] phase_ticks[] = '{9'd16, 9'd511, 9'd5, 9'd2, 9'd256, 9'd200};

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    ticks = PRICES;
    next_id = 1;
    clear_book();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_ticks(plan[i].cfg);
      end else begin
        send_request(plan[i].op, plan[i].side, plan[i].price, plan[i].qty,
                     plan[i].owner, plan[i].oid, plan[i].pos);
        // hand-written status must agree with the final record owed
        if (plan[i].has_exp && expected_recs[$].st != plan[i].exp_st)
          report("directed status", expected_recs[$].st, plan[i].exp_st);
      end
    end

    foreach (phase_ticks[k]) begin
      write_ticks(phase_ticks[k]);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (k == phase_ticks.size() - 1 && n >= RAND_PER_PHASE / 2) calm = 1;
        random_request();
      end
    end
    s_axis_tvalid <= 1'b0;

    while (expected_recs.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("limit_order_book_matcher test passed");
    end else begin
      $display("limit_order_book_matcher test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("limit_order_book_matcher test failed");
    $finish;
  end

endmodule
